### hdl/sdv_pkg.sv
// Package: status codes, register indexes and tag constants for the sfnt directory validator.
`timescale 1ns / 1ps
`default_nettype none

package sdv_pkg;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_COUNT  = 3'd1,
        ST_BAD_SEL    = 3'd2,
        ST_BAD_RANGE  = 3'd3,
        ST_BAD_TAG    = 3'd4,
        ST_OFS_IN_DIR = 3'd5,
        ST_PAST_LIMIT = 3'd6,
        ST_NO_REQ     = 3'd7
    } status_t;

    localparam logic [7:0] CFG_MIN_TABLES = 8'd0;
    localparam logic [7:0] CFG_MAX_TABLES = 8'd1;

    localparam logic [7:0] MIN_TABLES_RST = 8'd3;
    localparam logic [7:0] MAX_TABLES_RST = 8'd128;

    localparam logic [7:0] TAG_CHAR_LO = 8'h20;
    localparam logic [7:0] TAG_CHAR_HI = 8'h7E;

    localparam logic [31:0] TAG_HEAD = 32'h68656164;
    localparam logic [31:0] TAG_CMAP = 32'h636D6170;
    localparam logic [31:0] TAG_GLYF = 32'h676C7966;
    localparam logic [31:0] TAG_CFF  = 32'h43464620;

    localparam int HDR_BYTES   = 12;
    localparam int ENTRY_BYTES = 16;

endpackage

`default_nettype wire

### hdl/sfnt_directory_validator_core.sv
// Top level: byte-serial sfnt table directory validator.
//
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid / in_ready   | data_byte, start_of_candidate, limit
// out     | out | out_valid / out_ready | status, extent
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte per cycle unless the result register is blocked: an input register feeds one stage of checks
// that loads the result register, and a result is valid once its deciding byte has passed both.
// in_ready drops only while the input register holds a byte and the result register is full with out_ready low.
// Reset clears all control state and loads min_tables = 3, max_tables = 128; cfg_ready is always 1.
`timescale 1ns / 1ps
`default_nettype none

module sfnt_directory_validator_core #(
    parameter int MAX_TABLES = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        start_of_candidate,
    input  wire logic [31:0] limit,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      extent,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int PW = $clog2(sdv_pkg::ENTRY_BYTES * MAX_TABLES + sdv_pkg::HDR_BYTES + 1);
    localparam int CW = (PW > 9) ? PW : 9;

    // configuration
    logic [7:0] min_tables_reg;
    logic [7:0] max_tables_reg;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  byte_reg;
    logic        start_reg;
    logic [31:0] limit_in_reg;

    // candidate state
    logic [PW-1:0] pos_reg, pos_next;
    logic          active_reg, active_next;
    logic [7:0]    table_count_reg, table_count_next;
    logic [15:0]   search_range_reg, search_range_next;
    logic [15:0]   selector_reg, selector_next;
    logic [31:0]   field_shift_reg, field_shift_next;
    logic [31:0]   table_offset_reg, table_offset_next;
    logic [32:0]   furthest_end_reg, furthest_end_next;
    logic          saw_required_reg, saw_required_next;
    logic [31:0]   limit_held_reg, limit_held_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    sdv_pkg::status_t  status_reg, status_next;
    logic [31:0]       extent_reg, extent_next;

    // datapath
    logic              advance;
    logic              act;
    logic [PW-1:0]     p;
    logic [PW-1:0]     rel;
    logic [3:0]        k;
    logic [31:0]       fs;
    logic [15:0]       cnt;
    logic [11:0]       hi;
    logic [2:0]        sel;
    logic [12:0]       dir_end;
    logic [32:0]       tab_end;
    logic [32:0]       fe_new;
    logic              last_entry;
    logic              fire;
    sdv_pkg::status_t  code;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign extent    = extent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_tables_reg <= sdv_pkg::MIN_TABLES_RST;
            max_tables_reg <= sdv_pkg::MAX_TABLES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == sdv_pkg::CFG_MIN_TABLES)
                min_tables_reg <= cfg_data;
            else if (cfg_index == sdv_pkg::CFG_MAX_TABLES)
                max_tables_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg     <= data_byte;
            start_reg    <= start_of_candidate;
            limit_in_reg <= limit;
        end
    end

    always_comb
    begin
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    // floor(log2) of the table count
    always_comb
    begin
        sel = 3'd0;
        for (int i = 1; i < 8; i++)
        begin
            if (table_count_reg[i])
                sel = 3'(i);
        end
    end

    always_comb
    begin
        act        = start_reg || active_reg;
        p          = start_reg ? '0 : pos_reg;
        fs         = {(start_reg ? 24'd0 : field_shift_reg[23:0]), byte_reg};
        cnt        = fs[15:0];
        hi         = ({4'd0, max_tables_reg} < 12'(MAX_TABLES)) ? {4'd0, max_tables_reg}
                                                                : 12'(MAX_TABLES);
        rel        = p - PW'(sdv_pkg::HDR_BYTES);
        k          = rel[3:0];
        dir_end    = 13'(sdv_pkg::HDR_BYTES) + {1'b0, table_count_reg, 4'd0};
        tab_end    = {1'b0, table_offset_reg} + {1'b0, fs};
        fe_new     = (tab_end > furthest_end_reg) ? tab_end : furthest_end_reg;
        last_entry = (CW'(rel[PW-1:4]) + CW'(1)) >= CW'(table_count_reg);

        pos_next          = pos_reg;
        active_next       = active_reg;
        table_count_next  = table_count_reg;
        search_range_next = search_range_reg;
        selector_next     = selector_reg;
        field_shift_next  = field_shift_reg;
        table_offset_next = table_offset_reg;
        furthest_end_next = furthest_end_reg;
        saw_required_next = saw_required_reg;
        limit_held_next   = limit_held_reg;
        fire              = 1'b0;
        code              = sdv_pkg::ST_OK;

        if (advance)
        begin
            if (start_reg)
            begin
                table_count_next  = 8'd0;
                search_range_next = 16'd0;
                selector_next     = 16'd0;
                table_offset_next = 32'd0;
                furthest_end_next = 33'd0;
                saw_required_next = 1'b0;
                limit_held_next   = limit_in_reg;
            end
            active_next = act;
            if (act)
            begin
                pos_next         = p + PW'(1);
                field_shift_next = fs;
                if (p == PW'(5))
                begin
                    if (cnt < {8'd0, min_tables_reg} || cnt > {4'd0, hi} || cnt == 16'd0)
                    begin
                        fire = 1'b1;
                        code = sdv_pkg::ST_BAD_COUNT;
                    end
                    else
                    begin
                        table_count_next  = cnt[7:0];
                        furthest_end_next = 33'(sdv_pkg::HDR_BYTES) + {21'd0, cnt[7:0], 4'd0};
                    end
                end
                else if (p == PW'(7))
                begin
                    search_range_next = cnt;
                end
                else if (p == PW'(9))
                begin
                    selector_next = cnt;
                    if (cnt != 16'(sel))
                    begin
                        fire = 1'b1;
                        code = sdv_pkg::ST_BAD_SEL;
                    end
                    else if (search_range_reg != (16'd16 << sel))
                    begin
                        fire = 1'b1;
                        code = sdv_pkg::ST_BAD_RANGE;
                    end
                end
                else if (p >= PW'(sdv_pkg::HDR_BYTES))
                begin
                    if (k < 4'd4)
                    begin
                        if (byte_reg < sdv_pkg::TAG_CHAR_LO || byte_reg > sdv_pkg::TAG_CHAR_HI)
                        begin
                            fire = 1'b1;
                            code = sdv_pkg::ST_BAD_TAG;
                        end
                        else if (k == 4'd3 && (fs == sdv_pkg::TAG_HEAD || fs == sdv_pkg::TAG_CMAP
                                 || fs == sdv_pkg::TAG_GLYF || fs == sdv_pkg::TAG_CFF))
                        begin
                            saw_required_next = 1'b1;
                        end
                    end
                    else if (k == 4'd11)
                    begin
                        table_offset_next = fs;
                        if (fs < {19'd0, dir_end})
                        begin
                            fire = 1'b1;
                            code = sdv_pkg::ST_OFS_IN_DIR;
                        end
                    end
                    else if (k == 4'd15)
                    begin
                        if (tab_end > {1'b0, limit_held_reg})
                        begin
                            fire = 1'b1;
                            code = sdv_pkg::ST_PAST_LIMIT;
                        end
                        else
                        begin
                            furthest_end_next = fe_new;
                            if (last_entry)
                            begin
                                fire = 1'b1;
                                code = saw_required_reg ? sdv_pkg::ST_OK : sdv_pkg::ST_NO_REQ;
                            end
                        end
                    end
                end
                if (fire)
                    active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        status_next = status_reg;
        extent_next = extent_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            status_next    = code;
            extent_next    = (code == sdv_pkg::ST_OK) ? fe_new[31:0] : 32'd0;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            pos_reg          <= '0;
            active_reg       <= 1'b0;
            table_count_reg  <= 8'd0;
            search_range_reg <= 16'd0;
            selector_reg     <= 16'd0;
            field_shift_reg  <= 32'd0;
            table_offset_reg <= 32'd0;
            furthest_end_reg <= 33'd0;
            saw_required_reg <= 1'b0;
            limit_held_reg   <= 32'd0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            pos_reg          <= pos_next;
            active_reg       <= active_next;
            table_count_reg  <= table_count_next;
            search_range_reg <= search_range_next;
            selector_reg     <= selector_next;
            field_shift_reg  <= field_shift_next;
            table_offset_reg <= table_offset_next;
            furthest_end_reg <= furthest_end_next;
            saw_required_reg <= saw_required_next;
            limit_held_reg   <= limit_held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        extent_reg <= extent_next;
    end

    // a result only comes from a byte of an open candidate
    a_fire_active: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (advance && act))
        else $error("result without open candidate");

    // a result closes the candidate
    a_fire_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> !active_reg)
        else $error("candidate still open after result");

    // a held request is not lost while the result register is blocked
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(byte_reg) && $stable(start_reg)))
        else $error("input register changed while stalled");

    // failing status carries no extent, passing status carries at least the header and one entry
    a_extent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != sdv_pkg::ST_OK) |-> (extent_reg == 32'd0))
        else $error("nonzero extent on failure");

    a_extent_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == sdv_pkg::ST_OK) |-> (extent_reg >= 32'd28))
        else $error("extent below directory end on success");

    // selector word must match the encoded count on a passing candidate
    a_sel_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && code == sdv_pkg::ST_OK) |-> (selector_reg == 16'(sel)))
        else $error("passing candidate with bad selector");

endmodule

`default_nettype wire
